### design/tpst_pkg.sv
// Shared widths, types and constants for the triangle pair separating axis test.
`default_nettype none
package tpst_pkg;
	localparam int COORD_BITS_DEF = 24;
	localparam int CFG_BITS = 32;
	localparam int NUM_AXES = 11;
	localparam int AXIS_IDX_BITS = 4;
	localparam int CMD_QUEUE_DEPTH = 2;

	// Control part of one request handed from the front to the back: the vertex slot and its eval mark.
	typedef struct packed {
		logic       store_en;
		logic       tri_sel;
		logic [1:0] corner;
		logic       evaluate;
	} cmd_ctl_t;
endpackage
`default_nettype wire

### design/triangle_pair_sat_test_top.sv
// Top level of the triangle pair separating axis test.
//
//  channel  handshake            payload
//  input    push / full          triangle_select, corner, coord_x/y/z, evaluate
//  result   empty / pop          intersect_res
//  config   cfg_valid/cfg_ready  cfg_data (min_axis_length_sq)
//
// A vertex-only request only writes the vertex store. An evaluate request
// runs up to 11 axes: it builds the cross terms, then the axis, then its squared
// length, projects the six corners in low and high split-product phases, and then
// compares; lengths and projections use one shared multiplier bank. A degenerate axis
// drops out at its first projection step. A verdict not yet popped stalls the back end.
// Reset clears control and the threshold; the vertex store is undefined until written.
// A two-entry request queue lets the front accept while the back is busy.
`default_nettype none
module triangle_pair_sat_test_top import tpst_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic                         triangle_select,
	input  wire logic [1:0]                   corner,
	input  wire logic signed [COORD_BITS-1:0] coord_x,
	input  wire logic signed [COORD_BITS-1:0] coord_y,
	input  wire logic signed [COORD_BITS-1:0] coord_z,
	input  wire logic                         evaluate,
	output logic                              empty,
	input  wire logic                         pop,
	output logic                              intersect_res,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [CFG_BITS-1:0]          cfg_data
);
	logic                    cmd_valid, cmd_take, res_valid;
	cmd_ctl_t                cmd_ctl;
	logic [3*COORD_BITS-1:0] cmd_xyz;
	logic [CFG_BITS-1:0]     min_len_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) min_len_q <= '0;
		else if (cfg_valid) min_len_q <= cfg_data;
	end

	tpst_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk, .arst_n, .push, .full, .triangle_select, .corner,
		.coord_x, .coord_y, .coord_z, .evaluate,
		.cmd_valid, .cmd_take, .cmd_ctl, .cmd_xyz
	);

	tpst_back #(.COORD_BITS(COORD_BITS)) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_take, .cmd_ctl, .cmd_xyz,
		.min_len_sq(min_len_q), .res_valid, .res_take(pop), .res_bit(intersect_res)
	);

	assign empty = !res_valid;
endmodule
`default_nettype wire

### design/tpst_front.sv
// Front: accepts vertex requests and queues them for the back end.
`default_nettype none
module tpst_front import tpst_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic                         triangle_select,
	input  wire logic [1:0]                   corner,
	input  wire logic signed [COORD_BITS-1:0] coord_x,
	input  wire logic signed [COORD_BITS-1:0] coord_y,
	input  wire logic signed [COORD_BITS-1:0] coord_z,
	input  wire logic                         evaluate,
	output logic                              cmd_valid,
	input  wire logic                         cmd_take,
	output cmd_ctl_t                          cmd_ctl,
	output logic [3*COORD_BITS-1:0]           cmd_xyz
);
	localparam int PW = $clog2(CMD_QUEUE_DEPTH);
	cmd_ctl_t                ctl_q [CMD_QUEUE_DEPTH];
	logic [3*COORD_BITS-1:0] xyz_q [CMD_QUEUE_DEPTH];
	logic [PW-1:0]           wr_q, rd_q;
	logic [PW:0]             cnt_q;
	logic                    do_push, do_pop;
	cmd_ctl_t                in_ctl;

	always_comb begin
		in_ctl.store_en = (corner != 2'd3);
		in_ctl.tri_sel  = triangle_select;
		in_ctl.corner   = corner;
		in_ctl.evaluate = evaluate;
	end

	assign full      = (cnt_q == (PW+1)'(CMD_QUEUE_DEPTH));
	assign do_push   = push && !full;
	assign cmd_valid = (cnt_q != '0);
	assign do_pop    = cmd_valid && cmd_take;
	assign cmd_ctl   = ctl_q[rd_q];
	assign cmd_xyz   = xyz_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			ctl_q[wr_q] <= in_ctl;
			xyz_q[wr_q] <= {coord_z, coord_y, coord_x};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + PW'(1);
			if (do_pop)  rd_q <= rd_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(do_push) - (PW+1)'(do_pop);
		end
	end
endmodule
`default_nettype wire

### design/tpst_back.sv
// Back: stores vertices and runs the axis tests; lengths and projections share one multiplier bank.
`default_nettype none
module tpst_back import tpst_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cmd_valid,
	output logic                        cmd_take,
	input  cmd_ctl_t                    cmd_ctl,
	input  wire logic [3*COORD_BITS-1:0] cmd_xyz,
	input  wire logic [CFG_BITS-1:0]    min_len_sq,
	output logic                        res_valid,
	input  wire logic                   res_take,
	output logic                        res_bit
);
	localparam int EW = COORD_BITS + 1;        // edge
	localparam int AW = 2*EW + 1;              // axis component
	localparam int LW = 2*AW + 2;              // squared length
	localparam int PRW = AW + COORD_BITS + 2;  // projection
	localparam int LB = AW / 2;                // low slice of an axis component
	localparam int HW = AW - LB;               // high slice of an axis component
	localparam int OW0 = (HW > LB + 1) ? HW : LB + 1;
	localparam int OW = (OW0 > COORD_BITS) ? OW0 : COORD_BITS;  // multiplier operand
	localparam int SW = 2*OW + 2;              // sum of three products

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_AXA   = 7'b0000010,
		S_AXB   = 7'b0000100,
		S_LEN   = 7'b0001000,
		S_PRJ   = 7'b0010000,
		S_CMP   = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;
	logic signed [COORD_BITS-1:0] vs_q [2][3][3];
	logic [AXIS_IDX_BITS-1:0] axis_q;
	logic [2:0] vtx_q;  // projection index: 0..2 first triangle, 3..5 second
	logic [1:0] ph_q;   // partial-product phase
	logic signed [AW-1:0] ax_q [3];
	logic signed [2*EW-1:0] pa_q [3], pb_q [3];
	logic signed [LW-1:0] len_q, acc_q;
	logic signed [PRW-1:0] pmin_q, pmax_q, qmin_q, qmax_q;
	logic sep_q, out_valid_q, out_bit_q;

	logic signed [EW-1:0] ea [3], eb [3];
	logic signed [COORD_BITS-1:0] pv [3];
	logic signed [PRW-1:0] prj;
	logic [1:0] ia;
	logic       ib;

	function automatic logic signed [EW-1:0] edge_c(
		input logic signed [COORD_BITS-1:0] a, input logic signed [COORD_BITS-1:0] b);
		edge_c = EW'(a) - EW'(b);
	endfunction

	// Edge pair for the current axis: face normals first, then edge-by-edge.
	always_comb begin
		logic [1:0] e0, e1;
		logic       t0, t1;
		e0 = '0; e1 = '0; t0 = 1'b0; t1 = 1'b1;
		unique case (axis_q)
			AXIS_IDX_BITS'(0): begin
				e0 = 2'd0; e1 = 2'd1; t0 = 1'b0; t1 = 1'b0;
			end
			AXIS_IDX_BITS'(1): begin
				e0 = 2'd0; e1 = 2'd1; t0 = 1'b1; t1 = 1'b1;
			end
			AXIS_IDX_BITS'(2):  begin e0 = 2'd0; e1 = 2'd0; end
			AXIS_IDX_BITS'(3):  begin e0 = 2'd0; e1 = 2'd1; end
			AXIS_IDX_BITS'(4):  begin e0 = 2'd0; e1 = 2'd2; end
			AXIS_IDX_BITS'(5):  begin e0 = 2'd1; e1 = 2'd0; end
			AXIS_IDX_BITS'(6):  begin e0 = 2'd1; e1 = 2'd1; end
			AXIS_IDX_BITS'(7):  begin e0 = 2'd1; e1 = 2'd2; end
			AXIS_IDX_BITS'(8):  begin e0 = 2'd2; e1 = 2'd0; end
			AXIS_IDX_BITS'(9):  begin e0 = 2'd2; e1 = 2'd1; end
			default:            begin e0 = 2'd2; e1 = 2'd2; end
		endcase
		for (int k = 0; k < 3; k++) begin
			unique case (e0)
				2'd0:    ea[k] = edge_c(vs_q[t0][1][k], vs_q[t0][0][k]);
				2'd1:    ea[k] = edge_c(vs_q[t0][2][k], vs_q[t0][0][k]);
				default: ea[k] = edge_c(vs_q[t0][2][k], vs_q[t0][1][k]);
			endcase
			unique case (e1)
				2'd0:    eb[k] = edge_c(vs_q[t1][1][k], vs_q[t1][0][k]);
				2'd1:    eb[k] = edge_c(vs_q[t1][2][k], vs_q[t1][0][k]);
				default: eb[k] = edge_c(vs_q[t1][2][k], vs_q[t1][1][k]);
			endcase
		end
		ia = 2'(vtx_q >= 3'd3 ? vtx_q - 3'd3 : vtx_q);
		ib = (vtx_q >= 3'd3);
		for (int k = 0; k < 3; k++) pv[k] = vs_q[ib][ia][k];
	end

	// Shared multiplier bank: three split products per cycle, summed over phases.
	// Length: lo*lo, then lo*hi counted twice, then hi*hi. Projection: lo*v, then hi*v.
	logic signed [OW-1:0] ax_lo [3], ax_hi [3], ma [3], mb [3];
	logic signed [2*OW-1:0] mp [3];
	logic signed [SW-1:0] msum;
	logic signed [LW-1:0] term, accum;
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			ax_lo[k] = OW'($signed({1'b0, ax_q[k][LB-1:0]}));
			ax_hi[k] = OW'($signed(ax_q[k][AW-1:LB]));
			if (state_q == S_LEN) begin
				ma[k] = (ph_q == 2'd2) ? ax_hi[k] : ax_lo[k];
				mb[k] = (ph_q == 2'd0) ? ax_lo[k] : ax_hi[k];
			end else begin
				ma[k] = (ph_q == 2'd0) ? ax_lo[k] : ax_hi[k];
				mb[k] = OW'(pv[k]);
			end
			mp[k] = ma[k] * mb[k];
		end
		msum = SW'(mp[0]) + SW'(mp[1]) + SW'(mp[2]);
		priority if (state_q == S_LEN && ph_q == 2'd1) term = LW'(msum) <<< (LB + 1);
		else if (state_q == S_LEN && ph_q == 2'd2) term = LW'(msum) <<< (2 * LB);
		else if (state_q == S_PRJ && ph_q == 2'd1) term = LW'(msum) <<< LB;
		else term = LW'(msum);
		accum = acc_q + term;
		prj   = PRW'(accum);
	end

	assign cmd_take  = (state_q == S_IDLE) && cmd_valid && (!out_valid_q || res_take);
	assign res_valid = out_valid_q;
	assign res_bit   = out_bit_q;

	always_ff @(posedge clk) begin
		if (cmd_take && cmd_ctl.store_en) begin
			for (int k = 0; k < 3; k++)
				vs_q[cmd_ctl.tri_sel][cmd_ctl.corner][k] <=
					cmd_xyz[k*COORD_BITS +: COORD_BITS];
		end
		unique case (state_q)
			S_AXA: begin
				// Hold the six cross-product terms.
				pa_q[0] <= ea[1]*eb[2]; pb_q[0] <= ea[2]*eb[1];
				pa_q[1] <= ea[2]*eb[0]; pb_q[1] <= ea[0]*eb[2];
				pa_q[2] <= ea[0]*eb[1]; pb_q[2] <= ea[1]*eb[0];
			end
			S_AXB: begin
				for (int k = 0; k < 3; k++)
					ax_q[k] <= AW'(pa_q[k]) - AW'(pb_q[k]);
			end
			S_LEN: begin
				acc_q <= (ph_q == 2'd0) ? term : accum;
				if (ph_q == 2'd2) len_q <= accum;
			end
			S_PRJ: begin
				if (ph_q == 2'd0) begin
					acc_q <= term;
				end else if (vtx_q == 3'd0) begin
					pmin_q <= prj; pmax_q <= prj;
				end else if (vtx_q == 3'd3) begin
					qmin_q <= prj; qmax_q <= prj;
				end else if (vtx_q < 3'd3) begin
					if (prj < pmin_q) pmin_q <= prj;
					if (prj > pmax_q) pmax_q <= prj;
				end else begin
					if (prj < qmin_q) qmin_q <= prj;
					if (prj > qmax_q) qmax_q <= prj;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= '0;
			vtx_q       <= '0;
			ph_q        <= '0;
			sep_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_bit_q   <= 1'b0;
		end else begin
			if (out_valid_q && res_take && state_q != S_DONE) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_take && cmd_ctl.evaluate) begin
						state_q <= S_AXA;
						axis_q  <= '0;
						ph_q    <= '0;
						sep_q   <= 1'b0;
					end
				end
				S_AXA: state_q <= S_AXB;
				S_AXB: state_q <= S_LEN;
				S_LEN: begin
					if (ph_q == 2'd2) begin
						ph_q    <= '0;
						vtx_q   <= '0;
						state_q <= S_PRJ;
					end else begin
						ph_q <= ph_q + 2'd1;
					end
				end
				S_PRJ: begin
					// Skip a degenerate axis (squared length not above the threshold) at its first projection step.
					if (len_q <= $signed({1'b0, LW'(min_len_sq)})) begin
						state_q <= S_CMP;
						vtx_q   <= '0;
						ph_q    <= '0;
					end else if (ph_q == 2'd0) begin
						ph_q <= 2'd1;
					end else begin
						ph_q <= 2'd0;
						if (vtx_q == 3'd5)
							state_q <= S_CMP;
						else
							vtx_q <= vtx_q + 3'd1;
					end
				end
				S_CMP: begin
					if (vtx_q == 3'd5 && (pmax_q < qmin_q || qmax_q < pmin_q))
						sep_q <= 1'b1;
					if ((vtx_q == 3'd5 && (pmax_q < qmin_q || qmax_q < pmin_q)) ||
					    axis_q == AXIS_IDX_BITS'(NUM_AXES-1)) begin
						state_q <= S_DONE;
					end else begin
						axis_q  <= axis_q + AXIS_IDX_BITS'(1);
						state_q <= S_AXA;
					end
				end
				S_DONE: begin
					if (!out_valid_q || res_take) begin
						out_valid_q <= 1'b1;
						out_bit_q   <= !sep_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire
